@@ rtl/lfrp_pkg.sv @@
// Shared types and constants for the link failure recovery policy block.
`default_nettype none

package lfrp_pkg;

  // Event codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_LINK_UP     = 3'd0,
    MODE_CALL_OK     = 3'd1,
    MODE_TICK        = 3'd2,
    MODE_CALL_FAILED = 3'd3,
    MODE_RESTART     = 3'd4
  } mode_t;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RECOVER = 2'd1,
    ACT_GIVE_UP = 2'd2
  } action_t;

  // Configuration register indexes
  localparam logic [2:0] REG_FAILURE_THRESHOLD      = 3'd0;
  localparam logic [2:0] REG_PERSIST_TIME_MS        = 3'd1;
  localparam logic [2:0] REG_COOLDOWN_TIME_MS       = 3'd2;
  localparam logic [2:0] REG_RECOVERY_BUDGET        = 3'd3;
  localparam logic [2:0] REG_HEALTHY_TIME_MS        = 3'd4;
  localparam logic [2:0] REG_INITIAL_RECOVERY_COUNT = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int STREAK_MAX  = 255;

  typedef struct packed {
    logic [7:0]  failure_threshold;
    logic [31:0] persist_time_ms;
    logic [31:0] cooldown_time_ms;
    logic [3:0]  recovery_budget;
    logic [31:0] healthy_time_ms;
    logic [3:0]  initial_recovery_count;
  } cfg_t;

  // Result word fields
  typedef struct packed {
    logic       link_online;
    logic [3:0] recovery_count;
    action_t    action;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/lfrp_engine.sv @@
// Policy state registers and the single-pass next-state / result logic.
`default_nettype none

module lfrp_engine
  import lfrp_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [2:0]           mode,
  input  wire logic [TIME_BITS-1:0] now_time_ms,
  input  wire cfg_t                 cfg,
  output      result_t              result
);

  logic [7:0]           failure_streak;
  logic [TIME_BITS-1:0] first_failure_time;
  logic [TIME_BITS-1:0] online_since_time;
  logic [TIME_BITS-1:0] last_recovery_time;
  logic                 online_flag;
  logic                 gave_up_flag;
  logic [3:0]           recovery_counter;

  logic [7:0]           failure_streak_next;
  logic [TIME_BITS-1:0] first_failure_time_next;
  logic [TIME_BITS-1:0] online_since_time_next;
  logic [TIME_BITS-1:0] last_recovery_time_next;
  logic                 online_flag_next;
  logic                 gave_up_flag_next;
  logic [3:0]           recovery_counter_next;
  action_t              action;

  // now >= since and now - since >= limit
  function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] since,
                                   input logic [31:0]          limit);
    logic [TIME_BITS-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff >= TIME_BITS'(limit));
  endfunction

  // Health-clear check values (link up sees its own updated since time)
  logic [TIME_BITS-1:0] since_eff;
  logic                 online_eff;
  logic                 healthy_clear;

  // Failure path
  logic [TIME_BITS-1:0] fail_first;
  logic [7:0]           fail_streak;
  logic                 fail_ready;

  always_comb begin
    online_eff    = (mode == MODE_LINK_UP) ? 1'b1 : online_flag;
    since_eff     = (mode == MODE_LINK_UP && !online_flag) ? now_time_ms : online_since_time;
    healthy_clear = online_eff && (recovery_counter != 4'd0) &&
                    elapsed(now_time_ms, since_eff, cfg.healthy_time_ms);

    fail_first  = (failure_streak == 8'd0) ? now_time_ms : first_failure_time;
    fail_streak = (failure_streak == 8'(STREAK_MAX)) ? failure_streak : failure_streak + 8'd1;
    fail_ready  = (fail_streak >= cfg.failure_threshold) &&
                  elapsed(now_time_ms, fail_first, cfg.persist_time_ms) &&
                  elapsed(now_time_ms, last_recovery_time, cfg.cooldown_time_ms);
  end

  always_comb begin
    failure_streak_next     = failure_streak;
    first_failure_time_next = first_failure_time;
    online_since_time_next  = online_since_time;
    last_recovery_time_next = last_recovery_time;
    online_flag_next        = online_flag;
    gave_up_flag_next       = gave_up_flag;
    recovery_counter_next   = recovery_counter;
    action                  = ACT_NONE;

    case (mode)
      MODE_LINK_UP, MODE_CALL_OK, MODE_TICK: begin
        online_flag_next       = online_eff;
        online_since_time_next = since_eff;
        if (mode != MODE_TICK) begin
          failure_streak_next     = 8'd0;
          first_failure_time_next = '0;
        end
        if (healthy_clear) begin
          recovery_counter_next = 4'd0;
          gave_up_flag_next     = 1'b0;
        end
      end
      MODE_CALL_FAILED: begin
        online_flag_next        = 1'b0;
        failure_streak_next     = fail_streak;
        first_failure_time_next = fail_first;
        if (fail_ready) begin
          if (recovery_counter >= cfg.recovery_budget) begin
            if (!gave_up_flag) begin
              gave_up_flag_next = 1'b1;
              action            = ACT_GIVE_UP;
            end
          end else begin
            recovery_counter_next   = recovery_counter + 4'd1;
            last_recovery_time_next = now_time_ms;
            failure_streak_next     = 8'd0;
            first_failure_time_next = '0;
            action                  = ACT_RECOVER;
          end
        end
      end
      MODE_RESTART: begin
        failure_streak_next     = 8'd0;
        first_failure_time_next = '0;
        online_since_time_next  = '0;
        last_recovery_time_next = '0;
        online_flag_next        = 1'b0;
        gave_up_flag_next       = 1'b0;
        recovery_counter_next   = cfg.initial_recovery_count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_streak     <= '0;
      first_failure_time <= '0;
      online_since_time  <= '0;
      last_recovery_time <= '0;
      online_flag        <= 1'b0;
      gave_up_flag       <= 1'b0;
      recovery_counter   <= '0;
    end else if (step) begin
      failure_streak     <= failure_streak_next;
      first_failure_time <= first_failure_time_next;
      online_since_time  <= online_since_time_next;
      last_recovery_time <= last_recovery_time_next;
      online_flag        <= online_flag_next;
      gave_up_flag       <= gave_up_flag_next;
      recovery_counter   <= recovery_counter_next;
    end
  end

  assign result.action         = action;
  assign result.recovery_count = recovery_counter_next;
  assign result.link_online    = online_flag_next;

endmodule

`default_nettype wire

@@ rtl/link_failure_recovery_policy_core.sv @@
// Top level: config registers, input word register, policy engine and result register.
//
// Usage:
//   Input stream (s_*): one word per event, mode in the low 3 bits and the
//   millisecond timestamp above it. Output stream (m_*): one result word per
//   event, in order, carrying action, recovery count and link-online flag.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0..5);
//   write only while no event is in flight.
// Path: an accepted word is held in the input register and evaluated by the
//   policy logic; its result is loaded into the result register when that
//   register is free or its word is being taken, and then appears on m_tdata.
// Throughput: one event per cycle while m_tready is high. Each event reads the
//   state left by the one before it, and that update closes around the state
//   registers (a few subtract/compare paths on the timestamp).
// Reset: rst (synchronous) clears both stream stages and the policy state and
//   loads the configuration defaults (threshold 3, persist 30000 ms,
//   cooldown 600000 ms, budget 3, healthy 3600000 ms, initial count 0).
// Stall: with m_tready low the result register holds; one more word may sit
//   in the input register, after which s_tready drops until the result moves.
`default_nettype none

module link_failure_recovery_policy_core
  import lfrp_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  // [2:0] mode, [TIME_BITS+2:3] now_time_ms, zero padded to whole bytes
  input  wire logic [((TIME_BITS+10)/8)*8-1:0] s_tdata,
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  // [1:0] action, [5:2] recovery_count, [6] link_online, [7] zero
  output      logic [7:0]                   m_tdata,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_wdata
);

  cfg_t cfg;

  // Input word register
  logic                 in_valid;
  logic [2:0]           in_mode;
  logic [TIME_BITS-1:0] in_now;

  // Result register
  logic    out_valid;
  result_t out_result;

  result_t result;
  logic    advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failure_threshold      <= 8'd3;
      cfg.persist_time_ms        <= 32'd30000;
      cfg.cooldown_time_ms       <= 32'd600000;
      cfg.recovery_budget        <= 4'd3;
      cfg.healthy_time_ms        <= 32'd3600000;
      cfg.initial_recovery_count <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAILURE_THRESHOLD:      cfg.failure_threshold      <= cfg_wdata[7:0];
        REG_PERSIST_TIME_MS:        cfg.persist_time_ms        <= cfg_wdata;
        REG_COOLDOWN_TIME_MS:       cfg.cooldown_time_ms       <= cfg_wdata;
        REG_RECOVERY_BUDGET:        cfg.recovery_budget        <= cfg_wdata[3:0];
        REG_HEALTHY_TIME_MS:        cfg.healthy_time_ms        <= cfg_wdata;
        REG_INITIAL_RECOVERY_COUNT: cfg.initial_recovery_count <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tdata[2:0];
      in_now  <= s_tdata[3 +: TIME_BITS];
    end
  end

  lfrp_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .mode        (in_mode),
    .now_time_ms (in_now),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_result};

endmodule

`default_nettype wire
